// ===== hdl/pack_overtemp_torque_cap_assert.svh =====
// assertion macros for the pack over-temperature torque cap checker
`ifndef PACK_OVERTEMP_TORQUE_CAP_ASSERT_SVH
`define PACK_OVERTEMP_TORQUE_CAP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define POTC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("potc assertion failed");

// next-cycle implication, disabled during reset
`define POTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("potc assertion failed");

`endif

// ===== hdl/potc_pkg.sv =====
// shared types and constants of the pack over-temperature torque cap
package potc_pkg;
   localparam int TEMP_W    = 9;
   localparam int PCT_W     = 7;
   localparam int SHIFT_W   = 4;
   localparam int ACC_W     = 26;
   localparam int FRAC_W    = 16;
   localparam int DIV_W     = 16;
   localparam int DIVISOR_W = 9;
   localparam int CSR_IDX_W = 3;

   localparam logic [PCT_W-1:0] PCT_FULL   = PCT_W'(100);
   localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

   typedef logic signed [TEMP_W-1:0] temp_type;
   typedef logic [PCT_W-1:0]         pct_type;

   // register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PMIN    = 3'd0,
      REG_PMAX    = 3'd1,
      REG_SHIFT   = 3'd2,
      REG_START   = 3'd3,
      REG_LIMIT   = 3'd4,
      REG_FLOOR   = 3'd5,
      REG_UNKNOWN = 3'd6
   } csr_reg_type;

   // result of the lane merge
   typedef struct packed {
      logic     any;
      temp_type hottest;
   } max_type;
endpackage

// ===== hdl/potc_lane.sv =====
// one qualification lane: decides whether a module reading is usable
module potc_lane (
   input  logic              fresh,
   input  logic              mask_ok,
   input  logic              online,
   input  potc_pkg::temp_type temp,
   input  potc_pkg::temp_type plausible_min,
   input  potc_pkg::temp_type plausible_max,
   output logic              used
);
   import potc_pkg::*;

   logic in_window;

   assign in_window = (temp >= plausible_min) && (temp <= plausible_max);
   assign used      = fresh && (!mask_ok || online) && in_window;
endmodule

// ===== hdl/potc_merge.sv =====
// merge stage: hottest reading among the lanes that were used
module potc_merge #(
   parameter int MODULES = 5
) (
   input  logic [MODULES-1:0] used,
   input  potc_pkg::temp_type temps [MODULES],
   output potc_pkg::max_type  result
);
   import potc_pkg::*;

   always_comb begin
      result.any     = 1'b0;
      result.hottest = '0;
      for (int i = 0; i < MODULES; i++) begin
         if (used[i] && (!result.any || (temps[i] > result.hottest))) begin
            result.any     = 1'b1;
            result.hottest = temps[i];
         end
      end
   end
endmodule

// ===== hdl/potc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module potc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [potc_pkg::DIV_W-1:0]     dividend,
   input  logic [potc_pkg::DIVISOR_W-1:0] divisor,
   output logic [potc_pkg::DIV_W-1:0]     quotient,
   output logic                           done
);
   import potc_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;

   always_comb begin
      trial = {rem_ff, quo_ff[DIV_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = diff[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b1};
      end else begin
         rem_in = trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIV_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign quotient = quo_ff;
   assign done     = done_ff;
endmodule

// ===== hdl/pack_overtemp_torque_cap.sv =====
// top level of the pack over-temperature torque cap
//
//  channel | ports                     | contents
//  --------+---------------------------+------------------------------------------------
//  req     | req_tvalid/tready/tdata/  | online mask and MODULES temperatures in tdata,
//          | tuser                     | fresh flag and mask_ok in tuser
//  rsp     | rsp_tvalid/tready/tdata/  | used mask, cap, is_capped, filtered and hottest
//          | tuser                     | in tdata, temp_unknown in tuser
//  csr     | csr_valid/ready/index/data| register writes, ready whenever out of reset
//
// one transaction at a time: an unknown temperature goes straight to the result, a reading
// outside the ramp skips the divider, one inside the ramp needs its 16-step divider; the next
// request is taken from the cycle the result goes out
// synchronous active-high reset restores register defaults, unseeds the filter, sets the
// last cap to 100 and empties the result register
// the result register parts the two sides; a stalled rsp holds its transaction and the
// finished next result waits in the done state until the register is free
module pack_overtemp_torque_cap #(
   parameter int MODULES = 5
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata: online_mask, module_temp_0 .. module_temp_(MODULES-1), zero pad
   input  logic [((10*MODULES+7)/8)*8-1:0]       req_tdata,
   // tuser: fresh flag, mask_ok
   input  logic [1:0]                            req_tuser,
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata: used_mask, cap_percent, is_capped, filtered_temp, hottest_raw, zero pad
   output logic [((MODULES+26+7)/8)*8-1:0]       rsp_tdata,
   // tuser: temp_unknown
   output logic                                  rsp_tuser,
   // configuration writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [potc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [potc_pkg::TEMP_W-1:0]           csr_data
);
   import potc_pkg::*;

   localparam int OUT_W = ((MODULES+26+7)/8)*8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QUAL,
      ST_FILT,
      ST_RAMP,
      ST_DIVGO,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type state_ff;

   // configuration registers
   temp_type             pmin_ff, pmax_ff, start_ff, limit_ff;
   logic [SHIFT_W-1:0]   shift_ff;
   pct_type              floor_ff, unknown_ff;

   // captured request
   logic                 in_fresh_ff, in_mask_ok_ff;
   logic [MODULES-1:0]   in_online_ff;
   temp_type             in_temp_ff [MODULES];

   // per-item working registers
   logic [MODULES-1:0]   used_ff;
   logic                 any_ff;
   temp_type             hottest_ff;
   temp_type             temp_ff;
   logic [DIV_W-1:0]     prod_ff;
   logic [DIVISOR_W-1:0] span_ff;
   pct_type              res_cap_ff;
   logic                 res_unknown_ff;

   // filter state
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    seeded_ff;
   pct_type                 last_cap_ff;

   // result register
   logic                 rsp_valid_ff;
   logic [MODULES-1:0]   rsp_used_ff;
   logic                 rsp_unknown_ff;
   pct_type              rsp_cap_ff;
   temp_type             rsp_filt_ff, rsp_hot_ff;

   logic [MODULES-1:0]   lane_used;
   max_type              merged;
   logic [DIV_W-1:0]     div_q;
   logic                 div_done;
   logic                 div_start;
   logic                 req_fire;
   logic                 rsp_free;

   // filter arithmetic
   logic signed [ACC_W:0]   filt_diff, filt_step;
   logic [ACC_W-1:0]        rounded;
   temp_type                temp_now;
   // ramp arithmetic
   pct_type                 floor_cl, unknown_cl, unknown_cap;
   pct_type                 ramp_height;
   logic [TEMP_W:0]         t_minus_start, span_full;
   logic [PCT_W+DIVISOR_W-1:0] prod_full;

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = !reset;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign div_start  = (state_ff == ST_DIVGO);

   // configuration writes; unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         pmin_ff    <= TEMP_W'(-40);
         pmax_ff    <= TEMP_W'(120);
         shift_ff   <= SHIFT_W'(3);
         start_ff   <= TEMP_W'(45);
         limit_ff   <= TEMP_W'(60);
         floor_ff   <= PCT_W'(0);
         unknown_ff <= PCT_W'(60);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_PMIN:    pmin_ff    <= csr_data;
            REG_PMAX:    pmax_ff    <= csr_data;
            REG_SHIFT:   shift_ff   <= csr_data[SHIFT_W-1:0];
            REG_START:   start_ff   <= csr_data;
            REG_LIMIT:   limit_ff   <= csr_data;
            REG_FLOOR:   floor_ff   <= csr_data[PCT_W-1:0];
            REG_UNKNOWN: unknown_ff <= csr_data[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_fresh_ff   <= req_tuser[0];
         in_mask_ok_ff <= req_tuser[1];
         in_online_ff  <= req_tdata[MODULES-1:0];
         for (int i = 0; i < MODULES; i++) begin
            in_temp_ff[i] <= req_tdata[MODULES + TEMP_W*i +: TEMP_W];
         end
      end
   end

   // one qualification lane per module
   for (genvar g = 0; g < MODULES; g++) begin : g_lane
      potc_lane u_lane (
         .fresh         (in_fresh_ff),
         .mask_ok       (in_mask_ok_ff),
         .online        (in_online_ff[g]),
         .temp          (in_temp_ff[g]),
         .plausible_min (pmin_ff),
         .plausible_max (pmax_ff),
         .used          (lane_used[g])
      );
   end

   potc_merge #(.MODULES(MODULES)) u_merge (
      .used   (lane_used),
      .temps  (in_temp_ff),
      .result (merged)
   );

   potc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .quotient (div_q),
      .done     (div_done)
   );

   // filter update: seed with the target, else acc += floor((target - acc) / 2^shift)
   always_comb begin
      filt_diff = {{2{hottest_ff[TEMP_W-1]}}, hottest_ff, FRAC_W'(0)} - {acc_ff[ACC_W-1], acc_ff};
      filt_step = filt_diff >>> shift_ff;
      if (!seeded_ff) begin
         acc_in = {hottest_ff[TEMP_W-1], hottest_ff, FRAC_W'(0)};
      end else begin
         acc_in = acc_ff + filt_step[ACC_W-1:0];
      end
   end

   // rounded read-out of the filter
   assign rounded  = acc_ff + ROUND_HALF;
   assign temp_now = rounded[FRAC_W+TEMP_W-1:FRAC_W];

   // ramp operands, percent registers clamped to 100
   assign floor_cl      = (floor_ff > PCT_FULL) ? PCT_FULL : floor_ff;
   assign unknown_cl    = (unknown_ff > PCT_FULL) ? PCT_FULL : unknown_ff;
   assign unknown_cap   = (unknown_cl < last_cap_ff) ? unknown_cl : last_cap_ff;
   assign ramp_height   = PCT_FULL - floor_cl;
   assign t_minus_start = {temp_now[TEMP_W-1], temp_now} - {start_ff[TEMP_W-1], start_ff};
   assign span_full     = {limit_ff[TEMP_W-1], limit_ff} - {start_ff[TEMP_W-1], start_ff};
   assign prod_full     = ramp_height * t_minus_start[DIVISOR_W-1:0];

   // sequencer and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         acc_ff       <= '0;
         last_cap_ff  <= PCT_FULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         // result register: loaded from the done state, emptied when taken
         if ((state_ff == ST_DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_QUAL;
               end
            end
            ST_QUAL: begin
               used_ff    <= lane_used;
               any_ff     <= merged.any;
               hottest_ff <= merged.hottest;
               state_ff   <= ST_FILT;
            end
            ST_FILT: begin
               if (!any_ff) begin
                  // no usable reading: unseed and ratchet towards the unknown cap
                  seeded_ff      <= 1'b0;
                  res_cap_ff     <= unknown_cap;
                  res_unknown_ff <= 1'b1;
                  state_ff       <= ST_DONE;
               end else begin
                  acc_ff         <= acc_in;
                  seeded_ff      <= 1'b1;
                  res_unknown_ff <= 1'b0;
                  state_ff       <= ST_RAMP;
               end
            end
            ST_RAMP: begin
               temp_ff <= temp_now;
               priority if (temp_now <= start_ff) begin
                  res_cap_ff <= PCT_FULL;
                  state_ff   <= ST_DONE;
               end else if (temp_now >= limit_ff) begin
                  res_cap_ff <= floor_cl;
                  state_ff   <= ST_DONE;
               end else begin
                  // strictly inside the ramp, so both differences are positive
                  prod_ff  <= prod_full[DIV_W-1:0];
                  span_ff  <= span_full[DIVISOR_W-1:0];
                  state_ff <= ST_DIVGO;
               end
            end
            ST_DIVGO: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (div_done) begin
                  res_cap_ff <= PCT_FULL - div_q[PCT_W-1:0];
                  state_ff   <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  last_cap_ff <= res_cap_ff;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if ((state_ff == ST_DONE) && rsp_free) begin
         rsp_used_ff    <= used_ff;
         rsp_unknown_ff <= res_unknown_ff;
         rsp_cap_ff     <= res_cap_ff;
         rsp_filt_ff    <= res_unknown_ff ? '0 : temp_ff;
         rsp_hot_ff     <= res_unknown_ff ? '0 : hottest_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_unknown_ff;
   assign rsp_tdata  = OUT_W'({rsp_hot_ff, rsp_filt_ff, (rsp_cap_ff < PCT_FULL),
                               rsp_cap_ff, rsp_used_ff});
endmodule

// ===== hdl/potc_checker.sv =====
// port-level checker of the pack over-temperature torque cap and its bind
`include "pack_overtemp_torque_cap_assert.svh"

module potc_checker #(
   parameter int MODULES = 5
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [((10*MODULES+7)/8)*8-1:0]       req_tdata,
   input logic [1:0]                            req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [((MODULES+26+7)/8)*8-1:0]       rsp_tdata,
   input logic                                  rsp_tuser,
   input logic                                  csr_valid,
   input logic                                  csr_ready,
   input logic [potc_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [potc_pkg::TEMP_W-1:0]           csr_data
);
   import potc_pkg::*;

   logic [MODULES-1:0] rsp_used;
   pct_type            rsp_cap;
   logic               rsp_capped;
   temp_type           rsp_filt, rsp_hot;
   logic               req_fire;

   assign rsp_used   = rsp_tdata[MODULES-1:0];
   assign rsp_cap    = rsp_tdata[MODULES +: PCT_W];
   assign rsp_capped = rsp_tdata[MODULES + PCT_W];
   assign rsp_filt   = rsp_tdata[MODULES + PCT_W + 1 +: TEMP_W];
   assign rsp_hot    = rsp_tdata[MODULES + PCT_W + 1 + TEMP_W +: TEMP_W];
   assign req_fire   = req_tvalid && req_tready;

   // a stalled response holds its payload
   `POTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // unknown temperature reports no modules and zero temperatures
   `POTC_ASSERT_IMPL(a_unknown_zero, clock, reset, rsp_tvalid && rsp_tuser, (rsp_used == '0) && (rsp_filt == '0) && (rsp_hot == '0))

   // cap stays within 100 percent and the capped flag agrees with it
   `POTC_ASSERT_IMPL(a_cap_range, clock, reset, rsp_tvalid, (rsp_cap <= PCT_FULL) && (rsp_capped == (rsp_cap < PCT_FULL)))

   // one request in flight: no acceptance in the cycle after one
   `POTC_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_tready)
endmodule

bind pack_overtemp_torque_cap potc_checker #(.MODULES(MODULES)) u_potc_checker (.*);
